// ===== rtl/core/attribute_bitmap_pixel_colour_top_assert.svh =====
// Assertion macros for the core modules; only abpc_back includes them.
`ifndef ATTRIBUTE_BITMAP_PIXEL_COLOUR_TOP_ASSERT_SVH
`define ATTRIBUTE_BITMAP_PIXEL_COLOUR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define ABPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define ABPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/abpc_pkg.sv =====
`timescale 1ns / 1ps

package abpc_pkg;

    localparam int DEF_SCREEN_WIDTH  = 256;
    localparam int DEF_SCREEN_HEIGHT = 192;
    localparam int QUEUE_DEPTH       = 2;

    // Request codes on the input channel
    localparam logic [1:0] REQ_WR_BITMAP = 2'd0;
    localparam logic [1:0] REQ_WR_ATTR   = 2'd1;
    localparam logic [1:0] REQ_PIXEL     = 2'd2;

    // Operations queued between front and back
    typedef enum logic [1:0] {
        OP_WR_BITMAP,
        OP_WR_ATTR,
        OP_READ,
        OP_BLANK
    } op_kind_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } back_state_t;

    function automatic int cells_per_row(input int screen_width);
        return screen_width / 8;
    endfunction

    function automatic int bitmap_depth(input int screen_width, input int screen_height);
        return cells_per_row(screen_width) * screen_height;
    endfunction

    function automatic int attr_depth(input int screen_width, input int screen_height);
        return cells_per_row(screen_width) * (screen_height / 8);
    endfunction

    function automatic int idx_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // kind + bitmap index + attribute index + data byte + bit select
    function automatic int op_width(input int screen_width, input int screen_height);
        return 2 + idx_width(bitmap_depth(screen_width, screen_height))
                 + idx_width(attr_depth(screen_width, screen_height)) + 8 + 3;
    endfunction

    function automatic logic [1:0] channel_level(input logic [3:0] nibble,
                                                 input logic [1:0] ch);
        logic [1:0] level;
        if (!nibble[ch])
            level = 2'd0;
        else if (nibble[3])
            level = 2'd2;
        else
            level = 2'd1;
        return level;
    endfunction

endpackage

// ===== rtl/core/abpc_front.sv =====
`timescale 1ns / 1ps

module abpc_front #(
    parameter int SCREEN_WIDTH  = abpc_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = abpc_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic [1:0]  req_type,
    input  logic [12:0] addr,
    input  logic [7:0]  wdata,
    input  logic [7:0]  pix_x,
    input  logic [7:0]  pix_y,
    output logic        keep,
    output logic [abpc_pkg::op_width(SCREEN_WIDTH, SCREEN_HEIGHT)-1:0] op_data
);

    localparam int CELLS        = abpc_pkg::cells_per_row(SCREEN_WIDTH);
    localparam int BITMAP_DEPTH = abpc_pkg::bitmap_depth(SCREEN_WIDTH, SCREEN_HEIGHT);
    localparam int ATTR_DEPTH   = abpc_pkg::attr_depth(SCREEN_WIDTH, SCREEN_HEIGHT);
    localparam int BIDX_W       = abpc_pkg::idx_width(BITMAP_DEPTH);
    localparam int AIDX_W       = abpc_pkg::idx_width(ATTR_DEPTH);
    localparam int WIDE_W       = 14 + $clog2(CELLS + 1);

    typedef struct packed {
        abpc_pkg::op_kind_t  kind;
        logic [BIDX_W-1:0]   bidx;
        logic [AIDX_W-1:0]   aidx;
        logic [7:0]          wdata;
        logic [2:0]          bit_sel;
    } op_t;

    logic [WIDE_W-1:0] x_w;
    logic [WIDE_W-1:0] y_w;
    logic [WIDE_W-1:0] addr_w;
    logic [WIDE_W-1:0] bidx_w;
    logic [WIDE_W-1:0] aidx_w;
    logic              visible;
    op_t               op;

    assign x_w    = WIDE_W'(pix_x);
    assign y_w    = WIDE_W'(pix_y);
    assign addr_w = WIDE_W'(addr);

    assign bidx_w = y_w * WIDE_W'(CELLS) + (x_w >> 3);
    assign aidx_w = (y_w >> 3) * WIDE_W'(CELLS) + (x_w >> 3);

    assign visible = (x_w < WIDE_W'(SCREEN_WIDTH)) && (y_w < WIDE_W'(SCREEN_HEIGHT))
                  && (bidx_w < WIDE_W'(BITMAP_DEPTH)) && (aidx_w < WIDE_W'(ATTR_DEPTH));

    always_comb
    begin
        op.kind    = abpc_pkg::OP_BLANK;
        op.bidx    = bidx_w[BIDX_W-1:0];
        op.aidx    = aidx_w[AIDX_W-1:0];
        op.wdata   = wdata;
        op.bit_sel = ~pix_x[2:0];
        keep       = 1'b0;
        unique case (req_type)
            abpc_pkg::REQ_WR_BITMAP:
            begin
                op.kind = abpc_pkg::OP_WR_BITMAP;
                op.bidx = addr_w[BIDX_W-1:0];
                keep    = addr_w < WIDE_W'(BITMAP_DEPTH);
            end
            abpc_pkg::REQ_WR_ATTR:
            begin
                op.kind = abpc_pkg::OP_WR_ATTR;
                op.aidx = addr_w[AIDX_W-1:0];
                keep    = addr_w < WIDE_W'(ATTR_DEPTH);
            end
            abpc_pkg::REQ_PIXEL:
            begin
                // off-screen pixels still give one all-zero result
                op.kind = visible ? abpc_pkg::OP_READ : abpc_pkg::OP_BLANK;
                keep    = 1'b1;
            end
            default:
            begin
                // unused request code: drop
                keep = 1'b0;
            end
        endcase
    end

    assign op_data = op;

endmodule

// ===== rtl/core/abpc_queue.sv =====
`timescale 1ns / 1ps

module abpc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = abpc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/abpc_back.sv =====
`timescale 1ns / 1ps

`include "attribute_bitmap_pixel_colour_top_assert.svh"

module abpc_back #(
    parameter int SCREEN_WIDTH  = abpc_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = abpc_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  logic [abpc_pkg::op_width(SCREEN_WIDTH, SCREEN_HEIGHT)-1:0] q_data,
    output logic       q_pop,
    output logic       clearing,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    localparam int BITMAP_DEPTH = abpc_pkg::bitmap_depth(SCREEN_WIDTH, SCREEN_HEIGHT);
    localparam int ATTR_DEPTH   = abpc_pkg::attr_depth(SCREEN_WIDTH, SCREEN_HEIGHT);
    localparam int BIDX_W       = abpc_pkg::idx_width(BITMAP_DEPTH);
    localparam int AIDX_W       = abpc_pkg::idx_width(ATTR_DEPTH);

    typedef struct packed {
        abpc_pkg::op_kind_t  kind;
        logic [BIDX_W-1:0]   bidx;
        logic [AIDX_W-1:0]   aidx;
        logic [7:0]          wdata;
        logic [2:0]          bit_sel;
    } op_t;

    op_t                   op;
    abpc_pkg::back_state_t state_reg;
    abpc_pkg::back_state_t state_next;
    logic [BIDX_W-1:0]     clr_cnt_reg;
    logic [BIDX_W-1:0]     clr_cnt_next;

    logic                  bm_we;
    logic [BIDX_W-1:0]     bm_waddr;
    logic [7:0]            bm_wdata;
    logic                  at_we;
    logic [AIDX_W-1:0]     at_waddr;
    logic [7:0]            at_wdata;
    logic                  rd_en;

    logic [7:0]            bitmap_mem [BITMAP_DEPTH];
    logic [7:0]            attr_mem [ATTR_DEPTH];
    logic [7:0]            bm_rd_reg;
    logic [7:0]            at_rd_reg;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_blank_reg;
    logic [2:0]            s1_bit_reg;
    logic                  s1_adv;
    logic                  s1_free;

    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [1:0]            red_reg;
    logic [1:0]            green_reg;
    logic [1:0]            blue_reg;
    logic                  ink_reg;

    logic                  ink;
    logic [3:0]            nibble;

    assign op       = op_t'(q_data);
    assign clearing = state_reg == abpc_pkg::ST_CLEAR;

    assign s1_adv  = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s1_free = !s1_valid_reg || s1_adv;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        bm_we        = 1'b0;
        bm_waddr     = op.bidx;
        bm_wdata     = op.wdata;
        at_we        = 1'b0;
        at_waddr     = op.aidx;
        at_wdata     = op.wdata;
        unique case (state_reg)
            abpc_pkg::ST_CLEAR:
            begin
                // zero one bitmap entry per cycle, and the attribute entry of the same index while in range
                bm_we    = 1'b1;
                bm_waddr = clr_cnt_reg;
                bm_wdata = '0;
                at_we    = clr_cnt_reg < BIDX_W'(ATTR_DEPTH);
                at_waddr = clr_cnt_reg[AIDX_W-1:0];
                at_wdata = '0;
                if (clr_cnt_reg == BIDX_W'(BITMAP_DEPTH - 1))
                    state_next = abpc_pkg::ST_RUN;
                else
                    clr_cnt_next = clr_cnt_reg + BIDX_W'(1);
            end
            abpc_pkg::ST_RUN:
            begin
                if (q_valid)
                begin
                    unique case (op.kind)
                        abpc_pkg::OP_WR_BITMAP:
                        begin
                            q_pop = 1'b1;
                            bm_we = 1'b1;
                        end
                        abpc_pkg::OP_WR_ATTR:
                        begin
                            q_pop = 1'b1;
                            at_we = 1'b1;
                        end
                        abpc_pkg::OP_READ, abpc_pkg::OP_BLANK:
                        begin
                            // advance only when the read stage has room
                            if (s1_free)
                            begin
                                q_pop = 1'b1;
                                rd_en = 1'b1;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= abpc_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
            bitmap_mem[bm_waddr] <= bm_wdata;
        if (rd_en)
            bm_rd_reg <= bitmap_mem[op.bidx];
    end

    always_ff @(posedge clk)
    begin
        if (at_we)
            attr_mem[at_waddr] <= at_wdata;
        if (rd_en)
            at_rd_reg <= attr_mem[op.aidx];
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rd_en)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        m_tvalid_next = m_tvalid_reg;
        if (s1_adv)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_blank_reg <= op.kind == abpc_pkg::OP_BLANK;
            s1_bit_reg   <= op.bit_sel;
        end
    end

    assign ink    = bm_rd_reg[s1_bit_reg];
    assign nibble = ink ? at_rd_reg[3:0] : at_rd_reg[7:4];

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            if (s1_blank_reg)
            begin
                red_reg   <= 2'd0;
                green_reg <= 2'd0;
                blue_reg  <= 2'd0;
                ink_reg   <= 1'b0;
            end
            else
            begin
                red_reg   <= abpc_pkg::channel_level(nibble, 2'd0);
                green_reg <= abpc_pkg::channel_level(nibble, 2'd1);
                blue_reg  <= abpc_pkg::channel_level(nibble, 2'd2);
                ink_reg   <= ink;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, ink_reg, blue_reg, green_reg, red_reg};

    `ABPC_ASSERT_IMP(a_no_pop_in_clear, clearing, !q_pop, "queue popped during clearing pass")
    `ABPC_ASSERT_IMP(a_idle_in_clear, clearing, !s1_valid_reg && !m_tvalid_reg,
                     "result in flight during clearing pass")
    `ABPC_ASSERT_NXT(a_s1_hold, s1_valid_reg && !s1_adv,
                     s1_valid_reg && $stable(bm_rd_reg) && $stable(at_rd_reg),
                     "stalled read stage lost its data")

endmodule

// ===== rtl/core/attribute_bitmap_pixel_colour_top.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Signals                     | Fields
// s_      | in  | tvalid tready tdata tuser   | tuser: req_type; tdata: addr wdata pix_x pix_y
// m_      | out | tvalid tready tdata         | tdata: red/green/blue level, is_ink
//
// One item per cycle sustained while m_tready stays high; a pixel result passes from its
// transfer through the queue, the registered store read and the output register.
// After reset a clearing pass zeroes both stores, one bitmap entry per cycle, with
// s_tready low; the bitmap store has SCREEN_WIDTH/8*SCREEN_HEIGHT entries (6144 at defaults).
// A two-entry queue decouples the input side from the store side; writes drain
// while the output is stalled, pixel reads wait for room in the read stage.
module attribute_bitmap_pixel_colour_top #(
    parameter int SCREEN_WIDTH  = abpc_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = abpc_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // addr[12:0], wdata[20:13], pix_x[28:21], pix_y[36:29]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // red[1:0], green[3:2], blue[5:4], is_ink[6]
);

    localparam int OP_W = abpc_pkg::op_width(SCREEN_WIDTH, SCREEN_HEIGHT);

    logic            keep;
    logic [OP_W-1:0] front_op;
    logic            q_full;
    logic            q_not_empty;
    logic [OP_W-1:0] q_head;
    logic            q_pop;
    logic            clearing;
    logic            push;

    assign s_tready = !q_full && !clearing;
    assign push     = s_tvalid && s_tready && keep;

    abpc_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .req_type (s_tuser),
        .addr     (s_tdata[12:0]),
        .wdata    (s_tdata[20:13]),
        .pix_x    (s_tdata[28:21]),
        .pix_y    (s_tdata[36:29]),
        .keep     (keep),
        .op_data  (front_op)
    );

    abpc_queue #(
        .WIDTH (OP_W),
        .DEPTH (abpc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_op),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (q_head)
    );

    abpc_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_not_empty),
        .q_data   (q_head),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
